/* rtl/utf16_to_utf8_transcoder_top_defines.svh */
// Assertion macros shared by the transcoder checker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef UTF16_TO_UTF8_TRANSCODER_TOP_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U2U8_CHK_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("u2u8 check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define U2U8_CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u2u8 check failed: next-cycle implication");

`endif

/* rtl/u2u8_pkg.sv */
// Shared types, constants and encoding helpers for the UTF-16 to UTF-8 transcoder.
// No dependencies; used by the front end, queue, byte sequencer, top level and testbench.
package u2u8_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned MAX_BYTES   = 6;

	localparam logic [15:0] REPL_CP    = 16'hFFFD;
	localparam logic [15:0] CTRL_LIMIT = 16'd32;
	localparam logic [15:0] TAB_UNIT   = 16'd9;
	localparam logic [15:0] HI_FIRST   = 16'hD800;
	localparam logic [15:0] HI_LAST    = 16'hDBFF;
	localparam logic [15:0] LO_FIRST   = 16'hDC00;
	localparam logic [15:0] LO_LAST    = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;
	localparam logic [15:0] MAX_1BYTE  = 16'h007F;
	localparam logic [15:0] MAX_2BYTE  = 16'h07FF;

	localparam logic [7:0] LEAD2 = 8'hC0;
	localparam logic [7:0] LEAD3 = 8'hE0;
	localparam logic [7:0] LEAD4 = 8'hF0;
	localparam logic [7:0] CONT  = 8'h80;

	// Encoding of one basic-plane code point: up to three bytes, first byte at index 0.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      n;
	} bmp_t;

	// One request handed from the front end to the byte sequencer.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                count;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic bmp_t enc_bmp(input logic [15:0] v);
		bmp_t r;
		r = '0;
		if (v <= MAX_1BYTE) begin
			r.bytes[0] = v[7:0];
			r.n        = 2'd1;
		end else if (v <= MAX_2BYTE) begin
			r.bytes[0] = LEAD2 | {3'b000, v[10:6]};
			r.bytes[1] = CONT | {2'b00, v[5:0]};
			r.n        = 2'd2;
		end else begin
			r.bytes[0] = LEAD3 | {4'b0000, v[15:12]};
			r.bytes[1] = CONT | {2'b00, v[11:6]};
			r.bytes[2] = CONT | {2'b00, v[5:0]};
			r.n        = 2'd3;
		end
		return r;
	endfunction

endpackage

/* rtl/u2u8_front.sv */
// Front end: accepts code units, tracks a held high surrogate and builds byte requests.
// Depends on u2u8_pkg.
module u2u8_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 unit_valid,
	output logic                 unit_stall,
	input  logic [15:0]          code_unit,
	input  u2u8_pkg::q_status_t  q_status,
	output logic                 push,
	output u2u8_pkg::job_t       job
);

	logic        pend_valid_q;
	logic [9:0]  pend_bits_q;
	logic        accept;
	logic        is_ctrl;
	logic        is_hi;
	logic        is_lo;
	logic [20:0] supp_cp;
	u2u8_pkg::bmp_t bmp;

	assign unit_stall = q_status.full;
	assign accept     = unit_valid && !unit_stall;

	assign is_ctrl = (code_unit < u2u8_pkg::CTRL_LIMIT) && (code_unit != u2u8_pkg::TAB_UNIT);
	assign is_hi   = code_unit inside {[u2u8_pkg::HI_FIRST : u2u8_pkg::HI_LAST]};
	assign is_lo   = code_unit inside {[u2u8_pkg::LO_FIRST : u2u8_pkg::LO_LAST]};

	// Control units and high surrogates occupy no queue slot.
	assign push = accept && !is_ctrl && !is_hi;

	assign supp_cp = u2u8_pkg::SUPP_BASE + {1'b0, pend_bits_q, code_unit[9:0]};

	always_comb begin
		bmp = u2u8_pkg::enc_bmp(is_lo ? u2u8_pkg::REPL_CP : code_unit);
		job = '0;
		if (is_lo && pend_valid_q) begin
			job.bytes[0] = u2u8_pkg::LEAD4 | {5'b00000, supp_cp[20:18]};
			job.bytes[1] = u2u8_pkg::CONT | {2'b00, supp_cp[17:12]};
			job.bytes[2] = u2u8_pkg::CONT | {2'b00, supp_cp[11:6]};
			job.bytes[3] = u2u8_pkg::CONT | {2'b00, supp_cp[5:0]};
			job.count    = 3'd4;
		end else if (pend_valid_q && !is_lo) begin
			// The orphaned high surrogate becomes U+FFFD ahead of this unit.
			job.bytes[0] = 8'hEF;
			job.bytes[1] = 8'hBF;
			job.bytes[2] = 8'hBD;
			job.bytes[3] = bmp.bytes[0];
			job.bytes[4] = bmp.bytes[1];
			job.bytes[5] = bmp.bytes[2];
			job.count    = 3'd3 + {1'b0, bmp.n};
		end else begin
			job.bytes[0] = bmp.bytes[0];
			job.bytes[1] = bmp.bytes[1];
			job.bytes[2] = bmp.bytes[2];
			job.count    = {1'b0, bmp.n};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_bits_q  <= '0;
		end else if (accept) begin
			if (is_hi) begin
				pend_valid_q <= 1'b1;
				pend_bits_q  <= code_unit[9:0];
			end else if (!is_ctrl) begin
				pend_valid_q <= 1'b0;
				pend_bits_q  <= '0;
			end
		end
	end

endmodule

/* rtl/u2u8_queue.sv */
// Short request queue between the front end and the byte sequencer.
// Depends on u2u8_pkg.
module u2u8_queue #(
	parameter int unsigned DEPTH = u2u8_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u2u8_pkg::job_t      push_job,
	input  logic                pop,
	output u2u8_pkg::job_t      head_job,
	output u2u8_pkg::q_status_t q_status
);

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	u2u8_pkg::job_t   entry_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign q_status.full  = (count_q == FULL_CNT);
	assign q_status.empty = (count_q == '0);
	assign do_push  = push && !q_status.full;
	assign do_pop   = pop && !q_status.empty;
	assign head_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/u2u8_back.sv */
// Byte sequencer: walks the head request one byte per cycle into the output register, unless byte_stall holds it.
// Depends on u2u8_pkg.
module u2u8_back (
	input  logic                clk,
	input  logic                arst_n,
	input  u2u8_pkg::job_t      head_job,
	input  u2u8_pkg::q_status_t q_status,
	output logic                pop,
	output logic                byte_valid,
	input  logic                byte_stall,
	output logic [7:0]          utf8_byte,
	output logic                last_byte
);

	logic       byte_valid_q;
	logic [7:0] utf8_byte_q;
	logic       last_byte_q;
	logic [2:0] idx_q;
	logic       slot_free;
	logic       load;
	logic       is_last;

	assign slot_free = !byte_valid_q || !byte_stall;
	assign load      = slot_free && !q_status.empty;
	assign is_last   = (idx_q == (head_job.count - 3'd1));
	assign pop       = load && is_last;

	assign byte_valid = byte_valid_q;
	assign utf8_byte  = utf8_byte_q;
	assign last_byte  = last_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_q <= 1'b0;
			idx_q        <= '0;
		end else begin
			if (slot_free) begin
				byte_valid_q <= !q_status.empty;
			end
			if (load) begin
				idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			utf8_byte_q <= head_job.bytes[idx_q];
			last_byte_q <= is_last;
		end
	end

endmodule

/* rtl/utf16_to_utf8_transcoder_top.sv */
// Top level of the UTF-16 to UTF-8 transcoder: front end, request queue, byte sequencer.
// Depends on u2u8_pkg, u2u8_front, u2u8_queue and u2u8_back.
//
//   Channel   Handshake                Payload
//   unit      unit_valid / unit_stall  code_unit[15:0]
//   byte      byte_valid / byte_stall  utf8_byte[7:0], last_byte
//
// A code unit is taken every cycle while the request queue has room; control units
// and high surrogates are absorbed in that cycle and use no queue slot.
// The byte sequencer sends one byte per cycle unless byte_stall holds it; each request
// gives 1 to 6 bytes (typically 1 to 3) via the queue and then the output register.
// Reset clears the held surrogate, the queue and the output valid flag.
// byte_stall holds the output register; the queue absorbs QUEUE_DEPTH requests
// before unit_stall rises.
module utf16_to_utf8_transcoder_top #(
	parameter int unsigned QUEUE_DEPTH = u2u8_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        unit_valid,
	output logic        unit_stall,
	input  logic [15:0] code_unit,
	output logic        byte_valid,
	input  logic        byte_stall,
	output logic [7:0]  utf8_byte,
	output logic        last_byte
);

	u2u8_pkg::job_t      push_job;
	u2u8_pkg::job_t      head_job;
	u2u8_pkg::q_status_t q_status;
	logic                push;
	logic                pop;

	u2u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.code_unit  (code_unit),
		.q_status   (q_status),
		.push       (push),
		.job        (push_job)
	);

	u2u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.q_status (q_status)
	);

	u2u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_job   (head_job),
		.q_status   (q_status),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.utf8_byte  (utf8_byte),
		.last_byte  (last_byte)
	);

endmodule

/* rtl/u2u8_checker.sv */
// Port-level checks for the transcoder, attached to the top level by bind.
// Depends on utf16_to_utf8_transcoder_top_defines.svh.
`include "utf16_to_utf8_transcoder_top_defines.svh"

module u2u8_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        byte_valid,
	input logic        byte_stall,
	input logic [7:0]  utf8_byte,
	input logic        last_byte
);

	// A stalled byte holds its value.
	`U2U8_CHK_NEXT(a_hold, byte_valid && byte_stall, byte_valid && $stable(utf8_byte) && $stable(last_byte))
	// Bytes F8 to FF never occur in well-formed output.
	`U2U8_CHK_IMPLY(a_no_bad_lead, byte_valid, utf8_byte[7:3] != 5'b11111)
	// A multi-byte sequence never ends on a lead byte.
	`U2U8_CHK_IMPLY(a_last_cont, byte_valid && last_byte && utf8_byte[7], utf8_byte[7:6] == 2'b10)
	// Dropped control units never reach the output as single bytes.
	`U2U8_CHK_IMPLY(a_no_ctrl, byte_valid && last_byte && !utf8_byte[7], utf8_byte >= 8'd32 || utf8_byte == 8'd9)

endmodule

bind utf16_to_utf8_transcoder_top u2u8_checker u_u2u8_checker (.*);

/* tb/sv/testbench.sv */
// Self-checking testbench for utf16_to_utf8_transcoder_top: random and directed code units,
// predicted UTF-8 bytes checked in order. Depends on u2u8_pkg and the transcoder RTL.
`timescale 1ns / 1ps

// Predicts the byte stream from accepted code units and checks the bytes that come out.
class utf8_scoreboard;
	typedef struct {
		logic [7:0] value;
		logic       last;
	} utf8_out_t;

	bit         held_high;
	logic [9:0] held_bits;
	logic [7:0] burst[$];
	utf8_out_t  expected_bytes[$];
	int         n_errors;
	int         n_checked;

	function new();
		held_high = 1'b0;
		held_bits = '0;
		n_errors  = 0;
		n_checked = 0;
	endfunction

	function void flag(string msg);
		n_errors++;
		if (n_errors <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	function void add_byte(logic [7:0] b);
		burst.insert(burst.size(), b);
	endfunction

	function void append_cp(logic [20:0] cp);
		if (cp <= 21'h7F) begin
			add_byte(cp[7:0]);
		end else if (cp <= 21'h7FF) begin
			add_byte({3'b110, cp[10:6]});
			add_byte({2'b10, cp[5:0]});
		end else if (cp <= 21'hFFFF) begin
			add_byte({4'b1110, cp[15:12]});
			add_byte({2'b10, cp[11:6]});
			add_byte({2'b10, cp[5:0]});
		end else begin
			add_byte({5'b11110, cp[20:18]});
			add_byte({2'b10, cp[17:12]});
			add_byte({2'b10, cp[11:6]});
			add_byte({2'b10, cp[5:0]});
		end
	endfunction

	function void note_unit(logic [15:0] unit);
		utf8_out_t ob;
		// Control units vanish and leave a held high surrogate untouched.
		if (unit < u2u8_pkg::CTRL_LIMIT && unit != u2u8_pkg::TAB_UNIT)
			return;
		if (unit >= u2u8_pkg::HI_FIRST && unit <= u2u8_pkg::HI_LAST) begin
			held_high = 1'b1;
			held_bits = unit[9:0];
			return;
		end
		burst.delete();
		if (unit >= u2u8_pkg::LO_FIRST && unit <= u2u8_pkg::LO_LAST) begin
			if (held_high)
				append_cp(u2u8_pkg::SUPP_BASE + {1'b0, held_bits, unit[9:0]});
			else
				append_cp({5'b0, u2u8_pkg::REPL_CP});
		end else begin
			if (held_high)
				append_cp({5'b0, u2u8_pkg::REPL_CP});
			append_cp({5'b0, unit});
		end
		held_high = 1'b0;
		held_bits = '0;
		foreach (burst[i]) begin
			ob.value = burst[i];
			ob.last  = (i == burst.size() - 1);
			expected_bytes.insert(expected_bytes.size(), ob);
		end
	endfunction

	function void check_byte(logic [7:0] value, logic last);
		utf8_out_t ob;
		n_checked++;
		if (expected_bytes.size() == 0) begin
			flag($sformatf("byte %0d: unexpected %02h last %0b", n_checked, value, last));
			return;
		end
		ob = expected_bytes.pop_front();
		if (value !== ob.value || last !== ob.last)
			flag($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
				n_checked, ob.value, ob.last, value, last));
	endfunction
endclass

module testbench;
	typedef enum {
		UK_ASCII,
		UK_TWO_BYTE,
		UK_THREE_BYTE,
		UK_CONTROL,
		UK_PAIR,
		UK_LONE_LOW,
		UK_LONE_HIGH,
		UK_RAW
	} unit_kind_t;

	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_END  = 320;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        unit_valid = 1'b0;
	logic        unit_stall;
	logic [15:0] code_unit  = '0;
	logic        byte_valid;
	logic        byte_stall = 1'b0;
	logic [7:0]  utf8_byte;
	logic        last_byte;

	utf8_scoreboard sb = new();

	int tx_gap_max = 9;
	int rx_gap_max = 9;
	int units_sent = 0;
	bit hold_rx_req = 1'b0;

	utf16_to_utf8_transcoder_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.code_unit  (code_unit),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.utf8_byte  (utf8_byte),
		.last_byte  (last_byte)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic send_unit(input logic [15:0] unit);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap != 0) begin
			unit_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		unit_valid <= 1'b1;
		code_unit  <= unit;
		do @(posedge clk); while (!(unit_valid && !unit_stall));
		sb.note_unit(unit);
		units_sent++;
	endtask

	// A third of draws are surrogate pairs; the rest are BMP, control, lone and raw units.
	task automatic send_random();
		int         roll;
		unit_kind_t kind;
		logic [15:0] unit;
		roll = $urandom_range(0, 99);
		if (roll < 15)      kind = UK_ASCII;
		else if (roll < 25) kind = UK_TWO_BYTE;
		else if (roll < 37) kind = UK_THREE_BYTE;
		else if (roll < 42) kind = UK_CONTROL;
		else if (roll < 75) kind = UK_PAIR;
		else if (roll < 80) kind = UK_LONE_LOW;
		else if (roll < 86) kind = UK_LONE_HIGH;
		else                kind = UK_RAW;
		case (kind)
			UK_ASCII:      unit = 16'($urandom_range(32, 127));
			UK_TWO_BYTE:   unit = 16'($urandom_range('h80, 'h7FF));
			UK_THREE_BYTE: begin
				if ($urandom_range(0, 1) == 0)
					unit = 16'($urandom_range('h800, 'hD7FF));
				else
					unit = 16'($urandom_range('hE000, 'hFFFF));
			end
			UK_CONTROL:    unit = 16'($urandom_range(0, 31));
			UK_PAIR: begin
				send_unit(16'($urandom_range(u2u8_pkg::HI_FIRST, u2u8_pkg::HI_LAST)));
				// A control unit inside a pair must not break it.
				if ($urandom_range(0, 9) == 0)
					send_unit(16'($urandom_range(0, 8)));
				unit = 16'($urandom_range(u2u8_pkg::LO_FIRST, u2u8_pkg::LO_LAST));
			end
			UK_LONE_LOW:   unit = 16'($urandom_range(u2u8_pkg::LO_FIRST, u2u8_pkg::LO_LAST));
			UK_LONE_HIGH:  unit = 16'($urandom_range(u2u8_pkg::HI_FIRST, u2u8_pkg::HI_LAST));
			default:       unit = 16'($urandom());
		endcase
		send_unit(unit);
	endtask

	// Byte receiver: random stalls per byte, plus one long hold when requested.
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			if (hold_rx_req) begin
				byte_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx_req = 1'b0;
			end
			gap = $urandom_range(0, rx_gap_max);
			if (gap != 0) begin
				byte_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			byte_stall <= 1'b0;
			do @(posedge clk); while (!(byte_valid && !byte_stall));
			sb.check_byte(utf8_byte, last_byte);
		end
	end

	initial begin
		logic [15:0] directed_units[] = '{
			16'h0000, 16'h001F, 16'h0009, 16'h0020, 16'h007F, 16'h0080, 16'h07FF,
			16'h0800, 16'hFFFF, 16'hFFFD, 16'hDC00, 16'hDFFF,
			16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF,
			16'hD83D, 16'h0005, 16'hDE00,
			16'hDBFF, 16'hD800, 16'hDFFF,
			16'hD801, 16'h0041, 16'hDBC0, 16'hFFFF
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_units[i])
			send_unit(directed_units[i]);

		while (units_sent < 130)
			send_random();

		// The receiver holds off while requests keep coming, so the queue fills up.
		tx_gap_max  = 0;
		hold_rx_req = 1'b1;
		while (units_sent < 170)
			send_random();

		rx_gap_max = 0;
		while (units_sent < 230)
			send_random();

		tx_gap_max = 9;
		rx_gap_max = 9;
		while (units_sent < RANDOM_END)
			send_random();
		unit_valid <= 1'b0;

		while (sb.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (sb.n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#3000000;
		$display("tb: failure");
		$finish;
	end
endmodule

/* utf16_to_utf8_transcoder_top.f */
+incdir+rtl
rtl/u2u8_pkg.sv
rtl/u2u8_front.sv
rtl/u2u8_queue.sv
rtl/u2u8_back.sv
rtl/utf16_to_utf8_transcoder_top.sv
rtl/u2u8_checker.sv
tb/sv/testbench.sv
